// ===== design/pdqt_pkg.sv =====
// ----------------------------------------------------------------------------
// pdqt_pkg
// shared types and constants of the per-id quota table: payload structs,
// operation and verdict codes, controller/datapath command and status groups
// ----------------------------------------------------------------------------
package pdqt_pkg;

    localparam int ID_W    = 31;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 2;
    localparam int VERD_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0] QUOTA_RESET = 16'd3;

    // apb register map
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_QUOTA = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_RECORD = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [VERD_W-1:0] {
        VERDICT_ALLOWED = 2'd0,
        VERDICT_QUOTA   = 2'd1,
        VERDICT_FULL    = 2'd2,
        VERDICT_RSVD    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] person_id;
    } in_item_t;

    typedef struct packed {
        logic [VERD_W-1:0]  verdict;
        logic [COUNT_W-1:0] event_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch incoming item, restart scan
        logic read;      // issue table read at scan index
        logic compare;   // compare read beat against item id
        logic decide;    // form result, update table
        logic load_out;  // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic skip;      // clear op or empty table: no scan needed
        logic match;     // read entry holds the item id
        logic last;      // scan index is the last occupied slot
        logic out_free;  // output register can take a result
    } sts_t;

endpackage

// ===== design/pdqt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdqt_ctrl
// sequencer for one item: capture, scan occupied slots, decide, deliver
// ----------------------------------------------------------------------------
module pdqt_ctrl
    import pdqt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_DELIVER
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.skip)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                if (sts.match || sts.last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== design/pdqt_dpath.sv =====
// ----------------------------------------------------------------------------
// pdqt_dpath
// id/count table memory, scan index, fill level, verdict logic and the
// output register
// ----------------------------------------------------------------------------
module pdqt_dpath
    import pdqt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  in_item_t           in_data,
    input  logic [COUNT_W-1:0] quota,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_ENTRIES);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } entry_t;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    logic [OP_W-1:0]    op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               found_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    out_item_t          res_reg;
    out_item_t          res_next;
    out_item_t          out_data_reg;
    logic               out_valid_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               is_record;
    logic               table_full;
    logic [COUNT_W-1:0] inc_count;

    assign is_record  = (op_reg == OP_RECORD);
    assign table_full = (fill_reg == FILL_FULL);
    assign inc_count  = (hit_count_reg == COUNT_MAX) ? COUNT_MAX
                                                     : hit_count_reg + COUNT_W'(1);

    assign sts.skip     = (op_reg == OP_CLEAR) || (fill_reg == '0);
    assign sts.match    = (rd_data_reg.id == id_reg);
    assign sts.last     = ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg);
    assign sts.out_free = !out_valid_reg || !out_stall;

    // verdict and table update
    always_comb
    begin
        res_next  = '0;
        fill_next = fill_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = '0;
        if (op_reg == OP_CLEAR)
        begin
            fill_next = '0;
        end
        else if (found_reg)
        begin
            res_next.verdict     = (hit_count_reg < quota) ? VERDICT_ALLOWED
                                                           : VERDICT_QUOTA;
            res_next.event_count = hit_count_reg;
            if (is_record)
            begin
                res_next.event_count = inc_count;
                wr_en                = 1'b1;
                wr_data.id           = id_reg;
                wr_data.count        = inc_count;
            end
        end
        else
        begin
            res_next.verdict = table_full ? VERDICT_FULL : VERDICT_ALLOWED;
            if (is_record && !table_full)
            begin
                res_next.event_count = COUNT_W'(1);
                wr_en                = 1'b1;
                wr_addr              = fill_reg[IDX_W-1:0];
                wr_data.id           = id_reg;
                wr_data.count        = COUNT_W'(1);
                fill_next            = fill_reg + FILL_W'(1);
            end
        end
    end

    // table memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (cmd.decide && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // item payload and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_data.opcode;
            id_reg <= in_data.person_id;
        end
        if (cmd.compare && sts.match)
        begin
            hit_count_reg <= rd_data_reg.count;
        end
        if (cmd.decide)
        begin
            res_reg <= res_next;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    // scan control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.compare)
            begin
                if (sts.match)
                begin
                    found_reg <= 1'b1;
                end
                else if (!sts.last)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            if (cmd.decide)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/per_id_daily_quota_table_unit.sv =====
// ----------------------------------------------------------------------------
// per_id_daily_quota_table_unit
// per-identifier event counter table with a quota verdict; fills in order,
// emptied by a clear operation at each period boundary
//
//   channel  | direction | handshake          | beat
//   ---------+-----------+--------------------+------------------------------
//   in       | input     | in_valid/in_stall  | in_item_t {opcode, person_id}
//   out      | output    | out_valid/out_stall| out_item_t {verdict, count}
//   apb      | input     | psel/penable/pready| quota_per_period at offset 0
//
// scan: an item reads and compares each of the F occupied slots in turn (F up to
//   TABLE_ENTRIES); each slot is read through the table's one read port in a
//   read state, then compared against the item id in a compare state
// a hit ends the scan early; clear and empty-table items skip the scan
// one item at a time; the next beat is taken while a result still waits
// reset: control and fill level cleared at once, no clearing pass needed
// out_stall holds the result in the output register and the item behind it
// ----------------------------------------------------------------------------
module per_id_daily_quota_table_unit
    import pdqt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item input
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cmd_t               cmd;
    sts_t               sts;
    logic               busy;
    logic               start;
    logic [COUNT_W-1:0] quota_reg;
    logic               reg_sel;

    // register index from the word address
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    // quota register, written on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quota_reg <= QUOTA_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_QUOTA))
        begin
            quota_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // readback, unmapped offsets read zero
    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_QUOTA)
        begin
            prdata = PDATA_W'(quota_reg);
        end
    end

    // a beat is taken only while the sequencer is idle
    assign in_stall = busy;
    assign start    = in_valid && !busy;

    pdqt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pdqt_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .quota     (quota_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/pdqt_checker.sv =====
// ----------------------------------------------------------------------------
// pdqt_checker
// port-level checks on the quota table unit, bound to the top level
// ----------------------------------------------------------------------------
module pdqt_checker
    import pdqt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input out_item_t out_data,
    input logic      out_valid,
    input logic      out_stall
);

    // a held result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a held result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // one item at a time: taking a beat closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in progress");

    // a full-table verdict only comes for an absent id, so no count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.verdict == VERDICT_FULL) |-> (out_data.event_count == '0))
        else $error("table full verdict with nonzero count");

    // reserved verdict code never leaves the block
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.verdict != VERDICT_RSVD))
        else $error("reserved verdict code on output");

endmodule

bind per_id_daily_quota_table_unit pdqt_checker u_pdqt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
